[sv/hexp_pkg.sv]
// Shared types and constants for the half-precision exp pipeline.
`timescale 1ns / 1ps

package hexp_pkg;

  typedef logic [31:0] fp32_t;
  typedef logic signed [11:0] exp_t;

  // Single-precision constants of the range reduction and the polynomial
  localparam fp32_t MAGIC_BIAS     = 32'h4B40_007F;
  localparam fp32_t MAGIC_BIAS_NEG = 32'hCB40_007F;
  localparam fp32_t LOG2E          = 32'h3FB8_AA3B;
  localparam fp32_t MINUS_LN2      = 32'hBF31_7218;
  localparam fp32_t POLY_C1        = 32'h3F81_CF08;
  localparam fp32_t POLY_C2        = 32'h3EFF_9D19;
  localparam fp32_t FP_ONE         = 32'h3F80_0000;
  localparam fp32_t FP_NEG_ZERO    = 32'h8000_0000;
  localparam fp32_t DEFAULT_NAN    = 32'hFFC0_0000;
  localparam fp32_t QUIET_BIT      = 32'h0040_0000;

  // Shift that turns the rounded sum into the bits of 2^n
  localparam int SCALE_SHIFT = 23;

  // Half-precision magnitudes of the cutoff -9.703125 and of infinity
  localparam logic [14:0] CUTOFF_MAG   = 15'h48DA;
  localparam logic [14:0] HALF_INF_MAG = 15'h7C00;

endpackage

[sv/hexp_fma.sv]
// Three-stage single-precision fused multiply-add, round to nearest even.
`timescale 1ns / 1ps

module hexp_fma (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hexp_pkg::fp32_t a,
  input  hexp_pkg::fp32_t b,
  input  hexp_pkg::fp32_t c,
  output logic           out_valid,
  output hexp_pkg::fp32_t y
);
  import hexp_pkg::*;

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic        nan;
    exp_t        ex;
    logic [23:0] sig;
  } unp_t;

  typedef struct packed {
    logic        spec;
    fp32_t       spec_val;
    logic [47:0] prod;
    exp_t        ep;
    logic        sp;
    logic [23:0] csig;
    exp_t        ec;
    logic        sc;
    logic        cz;
  } mul_t;

  typedef struct packed {
    logic        spec;
    fp32_t       spec_val;
    logic [77:0] sum;
    exp_t        eb0;
    logic [6:0]  msb;
    logic        sign;
    logic        zero;
  } add_t;

  // Split a single value into fields, normalizing subnormals
  function automatic unp_t unpack(fp32_t v);
    unp_t u;
    logic [4:0] lz;
    logic found;
    u.sign = v[31];
    u.zero = (v[30:0] == 31'd0);
    u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    lz = 5'd0;
    found = 1'b0;
    if (v[30:23] != 8'd0) begin
      u.ex  = exp_t'({4'b0, v[30:23]}) - exp_t'(127);
      u.sig = {1'b1, v[22:0]};
    end else begin
      for (int i = 22; i >= 0; i--) begin
        if (!found && v[i]) begin
          lz = 5'(23 - i);
          found = 1'b1;
        end
      end
      u.sig = {1'b0, v[22:0]} << lz;
      u.ex  = exp_t'(-126) - exp_t'({7'b0, lz});
    end
    return u;
  endfunction

  unp_t ua, ub, uc;
  mul_t mul_next, mul_r;
  add_t add_next, add_r;
  fp32_t y_next;
  logic v1, v2;

  // Stage 1: operand decode, special cases, significand product
  always_comb begin
    logic sp;
    ua = unpack(a);
    ub = unpack(b);
    uc = unpack(c);
    sp = ua.sign ^ ub.sign;
    mul_next.spec     = 1'b1;
    mul_next.spec_val = DEFAULT_NAN;
    if (ua.nan) begin
      mul_next.spec_val = a | QUIET_BIT;
    end else if (ub.nan) begin
      mul_next.spec_val = b | QUIET_BIT;
    end else if (uc.nan) begin
      mul_next.spec_val = c | QUIET_BIT;
    end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      mul_next.spec_val = DEFAULT_NAN;
    end else if (ua.inf || ub.inf) begin
      if (uc.inf && (uc.sign != sp)) mul_next.spec_val = DEFAULT_NAN;
      else mul_next.spec_val = {sp, 31'h7F80_0000};
    end else if (uc.inf) begin
      mul_next.spec_val = c;
    end else if (ua.zero || ub.zero) begin
      if (uc.zero) mul_next.spec_val = {sp & uc.sign, 31'd0};
      else mul_next.spec_val = c;
    end else begin
      mul_next.spec = 1'b0;
    end
    mul_next.prod = ua.sig * ub.sig;
    mul_next.ep   = ua.ex + ub.ex;
    mul_next.sp   = sp;
    mul_next.csig = uc.sig;
    mul_next.ec   = uc.ex;
    mul_next.sc   = uc.sign;
    mul_next.cz   = uc.zero;
  end

  // Stage 2: align the addend against the product, add, find leading one
  always_comb begin
    exp_t d, shv;
    logic [6:0] sh;
    logic [77:0] pwin, cwin, cfull, mask;
    logic [78:0] diff;
    d     = mul_r.ec - mul_r.ep + exp_t'(23);
    pwin  = {27'd0, mul_r.prod, 3'd0};
    cfull = {1'b0, mul_r.csig, 53'd0};
    cwin  = 78'd0;
    shv   = exp_t'(0);
    sh    = 7'd0;
    mask  = 78'd0;
    add_next.eb0 = mul_r.ep - exp_t'(49);
    if (mul_r.cz) begin
      cwin = 78'd0;
    end else if (d > exp_t'(50)) begin
      // addend dominates: product only contributes a sticky bit
      cwin = cfull;
      pwin = {77'd0, |mul_r.prod};
      add_next.eb0 = mul_r.ec - exp_t'(76);
    end else begin
      shv  = exp_t'(50) - d;
      sh   = (shv > exp_t'(78)) ? 7'd78 : shv[6:0];
      mask = ~({78{1'b1}} << sh);
      cwin = (cfull >> sh) | {77'd0, |(cfull & mask)};
    end
    diff = {1'b0, pwin} - {1'b0, cwin};
    if (mul_r.sp == mul_r.sc) begin
      add_next.sum  = pwin + cwin;
      add_next.sign = mul_r.sp;
    end else if (diff[78]) begin
      add_next.sum  = cwin - pwin;
      add_next.sign = mul_r.sc;
    end else begin
      add_next.sum  = diff[77:0];
      add_next.sign = mul_r.sp;
    end
    add_next.zero = (add_next.sum == 78'd0);
    add_next.msb  = 7'd0;
    for (int i = 0; i < 78; i++) begin
      if (add_next.sum[i]) add_next.msb = 7'(i);
    end
    add_next.spec     = mul_r.spec;
    add_next.spec_val = mul_r.spec_val;
  end

  // Stage 3: normalize, round to nearest even, pack
  always_comb begin
    exp_t lsh_n, lsh_s, lsh, rsv, efv;
    logic [6:0] rs;
    logic [77:0] m;
    logic sticky_r, g, st, inc;
    logic [23:0] mant;
    logic [32:0] bits;
    lsh_n = exp_t'(77) - exp_t'({5'b0, add_r.msb});
    lsh_s = exp_t'(203) + add_r.eb0;
    lsh   = (lsh_s < lsh_n) ? lsh_s : lsh_n;
    rsv   = -lsh;
    rs    = 7'd0;
    if (lsh >= exp_t'(0)) begin
      m = add_r.sum << lsh[6:0];
      sticky_r = 1'b0;
    end else begin
      rs = (rsv > exp_t'(78)) ? 7'd78 : rsv[6:0];
      m = add_r.sum >> rs;
      sticky_r = |(add_r.sum & ~({78{1'b1}} << rs));
    end
    mant = m[77:54];
    g    = m[53];
    st   = (|m[52:0]) | sticky_r;
    inc  = g & (st | mant[0]);
    efv  = add_r.eb0 + exp_t'(203) - lsh;
    bits = {efv[9:0], 23'd0} + {9'd0, mant} + {32'd0, inc};
    if (add_r.spec) begin
      y_next = add_r.spec_val;
    end else if (add_r.zero) begin
      y_next = 32'd0;
    end else if (bits >= 33'h0_7F80_0000) begin
      y_next = {add_r.sign, 31'h7F80_0000};
    end else begin
      y_next = {add_r.sign, bits[30:0]};
    end
  end

  // Advance payload every cycle
  always_ff @(posedge clk) begin
    mul_r <= mul_next;
    add_r <= add_next;
    y     <= y_next;
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

[sv/half_exp_nonpositive_unit.sv]
// Top level: exp(x) of one half-precision value per cycle through a fused multiply-add pipeline.
`timescale 1ns / 1ps

// Usage
//   Pulse start with x_half and last_element; the item transfers at that clock edge.
//   busy is always low: an item may transfer in every cycle, back to back.
//   Each result appears on y_half and last_out for exactly one cycle with done high,
//   once its input has passed the input register, the pipe and the output register, in input order.
//   Throughput is one item per cycle; an item passes through five dependent fused
//   multiply-adds of three stages each, plus one input and one output register.
//   The receiver cannot hold results off, so nothing is buffered beyond the pipe.
//   Inputs below -9.703125 (and -inf) give +0; NaN comes back quieted.
//   Reset clears all valid bits; the pipe drains no stale results after reset.
//   Accuracy is intended for -9.703125 <= x <= 0; other values follow the same
//   arithmetic without correction.
module half_exp_nonpositive_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] x_half,
  input  logic        last_element,
  output logic        done,
  output logic [15:0] y_half,
  output logic        last_out
);
  import hexp_pkg::*;

  typedef struct packed {
    logic cut;
    logic last;
  } side_t;

  // Widen a half value exactly to single precision
  function automatic fp32_t half_to_float(logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [7:0] e32;
    logic [9:0] mn;
    fp32_t r;
    e = h[14:10];
    m = h[9:0];
    e32 = 8'd0;
    mn = 10'd0;
    if (e == 5'd31) begin
      r = {h[15], 8'hFF, (m != 10'd0), m[8:0], 13'd0};
    end else if (e == 5'd0) begin
      for (int k = 0; k < 10; k++) begin
        if (m[k]) begin
          e32 = 8'(103 + k);
          mn  = m << (10 - k);
        end
      end
      if (m == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], e32, mn, 13'd0};
    end else begin
      r = {h[15], 8'({3'b0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // Round a single value to half precision, nearest even
  function automatic logic [15:0] float_to_half(fp32_t f);
    logic sgn;
    logic [7:0] e;
    logic [22:0] m;
    logic [23:0] full, q, rem, halfw, mask;
    logic [4:0] sh;
    logic [11:0] q1;
    logic inc;
    logic [15:0] r;
    sgn = f[31];
    e = f[30:23];
    m = f[22:0];
    full = {1'b1, m};
    sh = (e >= 8'd113) ? 5'd13 : 5'(8'd126 - e);
    q = full >> sh;
    mask = (24'd1 << sh) - 24'd1;
    rem = full & mask;
    halfw = 24'd1 << (sh - 5'd1);
    inc = (rem > halfw) || ((rem == halfw) && q[0]);
    q1 = q[11:0] + {11'd0, inc};
    if (e == 8'hFF) begin
      if (m != 23'd0) r = {sgn, 15'h7E00 | {5'd0, m[22:13]}};
      else r = {sgn, HALF_INF_MAG};
    end else if (e == 8'd0) begin
      r = {sgn, 15'd0};
    end else if (e > 8'd142) begin
      r = {sgn, HALF_INF_MAG};
    end else if (e < 8'd102) begin
      // below half of the smallest subnormal: always rounds to zero
      r = {sgn, 15'd0};
    end else if (e >= 8'd113) begin
      r = {sgn, 15'({e - 8'd113, 10'd0}) + {3'd0, q1}};
    end else begin
      r = {sgn, 3'd0, q1};
    end
    return r;
  endfunction

  fp32_t x_r;
  side_t side_in;
  logic  v0;

  fp32_t n1, n2, t, p, ts, f;
  logic  n1_v, n2_v, t_v, p_v, ts_v, f_v;

  fp32_t x_line [6];
  fp32_t s_line [9];
  side_t side_line [15];

  assign busy = 1'b0;

  // Capture the input and flag values below the cutoff
  always_ff @(posedge clk) begin
    x_r          <= half_to_float(x_half);
    side_in.cut  <= x_half[15] && (x_half[14:0] > CUTOFF_MAG) &&
                    (x_half[14:0] <= HALF_INF_MAG);
    side_in.last <= last_element;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  // n1 = x*log2(e) + bias
  hexp_fma u_fma_round (
    .clk(clk), .rst(rst), .in_valid(v0),
    .a(x_r), .b(LOG2E), .c(MAGIC_BIAS),
    .out_valid(n1_v), .y(n1)
  );

  // n2 = n1 - bias
  hexp_fma u_fma_unbias (
    .clk(clk), .rst(rst), .in_valid(n1_v),
    .a(n1), .b(FP_ONE), .c(MAGIC_BIAS_NEG),
    .out_valid(n2_v), .y(n2)
  );

  // t = x - n*ln2
  hexp_fma u_fma_reduce (
    .clk(clk), .rst(rst), .in_valid(n2_v),
    .a(n2), .b(MINUS_LN2), .c(x_line[5]),
    .out_valid(t_v), .y(t)
  );

  // p = c1 + t*c2
  hexp_fma u_fma_poly (
    .clk(clk), .rst(rst), .in_valid(t_v),
    .a(POLY_C2), .b(t), .c(POLY_C1),
    .out_valid(p_v), .y(p)
  );

  // ts = t*s
  hexp_fma u_fma_scale (
    .clk(clk), .rst(rst), .in_valid(t_v),
    .a(t), .b(s_line[5]), .c(FP_NEG_ZERO),
    .out_valid(ts_v), .y(ts)
  );

  // f = s + ts*p
  hexp_fma u_fma_final (
    .clk(clk), .rst(rst), .in_valid(p_v & ts_v),
    .a(ts), .b(p), .c(s_line[8]),
    .out_valid(f_v), .y(f)
  );

  // Hold x, the scale and the side flags until their stage needs them
  always_ff @(posedge clk) begin
    x_line[0]    <= x_r;
    s_line[0]    <= n1 << SCALE_SHIFT;
    side_line[0] <= side_in;
    for (int k = 1; k < 6; k++) x_line[k] <= x_line[k-1];
    for (int k = 1; k < 9; k++) s_line[k] <= s_line[k-1];
    for (int k = 1; k < 15; k++) side_line[k] <= side_line[k-1];
  end

  // Round to half and drive the result transfer
  always_ff @(posedge clk) begin
    y_half   <= side_line[14].cut ? 16'h0000 : float_to_half(f);
    last_out <= side_line[14].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_v;
    end
  end

endmodule
